FILE: rtl/core/ttrrs_pkg.sv
// Package for the thread table round-robin scheduler.
// Holds table size, field widths, command/status/slot codes and pointer helpers.
// No dependencies.
package ttrrs_pkg;

  localparam int unsigned MaxThreads = 16;
  localparam int unsigned SlotW      = $clog2(MaxThreads);
  localparam int unsigned MaskW      = 64;
  localparam int unsigned IdW        = 4;

  typedef logic [SlotW-1:0] slot_t;
  typedef logic [MaskW-1:0] mask_t;

  typedef enum logic [2:0] {
    KindStart    = 3'd0,
    KindRun      = 3'd1,
    KindSchedule = 3'd2,
    KindExit     = 3'd3,
    KindSuspend  = 3'd4,
    KindResume   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    StatOk         = 2'd0,
    StatNoSlot     = 2'd1,
    StatNotRunning = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SlotUnused   = 2'd0,
    SlotRunnable = 2'd1,
    SlotBlocked  = 2'd2,
    SlotExited   = 2'd3
  } slot_state_e;

  typedef enum logic [1:0] {
    FsmIdle,
    FsmPrime,
    FsmScan
  } fsm_e;

  // Advance a slot pointer with wrap at the table size.
  function automatic slot_t slot_inc(slot_t s);
    return (s == slot_t'(MaxThreads - 1)) ? '0 : s + slot_t'(1);
  endfunction

endpackage

FILE: rtl/core/thread_table_round_robin_scheduler.sv
// Top level of the thread table round-robin scheduler.
// Depends on ttrrs_pkg and ttrrs_ram (wait masks).
//
// A request is taken when start is high and busy is low; its result shows on
// status_o, thread_id_o and switched_o for exactly one cycle with valid_o high, and
// the receiver cannot stall it. Start, run, resume and requests refused because the
// scheduler is not yet running answer on the cycle after acceptance and leave busy
// low. Schedule, exit and suspend walk the slot table round-robin, one slot per cycle
// through the registered read port of the wait-mask memory, examining 1 to MaxThreads
// slots; busy is high until the result cycle, when a new request can be taken.
// Slot states and joinable bits sit in flops that reset clears; a wait mask is only
// read for a blocked slot, whose mask the suspend has written, so no clearing pass.
module thread_table_round_robin_scheduler (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            kind_i,
  input  logic                  joinable_flag_i,
  input  logic [63:0]           channel_mask_i,
  output logic                  valid_o,
  output logic [1:0]            status_o,
  output logic [3:0]            thread_id_o,
  output logic                  switched_o
);

  ttrrs_pkg::fsm_e        fsm_q, fsm_d;
  ttrrs_pkg::slot_state_e state_q [ttrrs_pkg::MaxThreads];
  ttrrs_pkg::slot_state_e state_d [ttrrs_pkg::MaxThreads];
  logic                   join_q  [ttrrs_pkg::MaxThreads];
  logic                   join_d  [ttrrs_pkg::MaxThreads];

  ttrrs_pkg::slot_t cur_q, cur_d;
  ttrrs_pkg::slot_t idle_q, idle_d;
  ttrrs_pkg::slot_t rot_q, rot_d;
  ttrrs_pkg::slot_t look_q, look_d;
  ttrrs_pkg::slot_t cnt_q, cnt_d;
  logic             running_q, running_d;
  ttrrs_pkg::mask_t pend_q, pend_d;
  ttrrs_pkg::mask_t ev_q, ev_d;

  logic                       valid_q, valid_d;
  ttrrs_pkg::status_e         status_q, status_d;
  logic [ttrrs_pkg::IdW-1:0]  id_q, id_d;
  logic                       switched_q, switched_d;

  logic             ram_we;
  ttrrs_pkg::slot_t ram_raddr;
  ttrrs_pkg::mask_t ram_rdata;

  logic             free_found;
  ttrrs_pkg::slot_t free_slot;
  logic             hit;
  ttrrs_pkg::slot_t next_slot;

  ttrrs_ram #(
    .Width (ttrrs_pkg::MaskW),
    .Depth (ttrrs_pkg::MaxThreads)
  ) u_wait_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cur_q),
    .wdata_i (channel_mask_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Lowest unused slot.
  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = ttrrs_pkg::MaxThreads - 1; i >= 0; i--) begin
      if (state_q[i] == ttrrs_pkg::SlotUnused) begin
        free_found = 1'b1;
        free_slot  = ttrrs_pkg::slot_t'(i);
      end
    end
  end

  always_comb begin
    fsm_d      = fsm_q;
    state_d    = state_q;
    join_d     = join_q;
    cur_d      = cur_q;
    idle_d     = idle_q;
    rot_d      = rot_q;
    look_d     = look_q;
    cnt_d      = cnt_q;
    running_d  = running_q;
    pend_d     = pend_q;
    ev_d       = ev_q;
    valid_d    = 1'b0;
    status_d   = status_q;
    id_d       = id_q;
    switched_d = switched_q;
    ram_we     = 1'b0;
    ram_raddr  = rot_q;
    hit        = 1'b0;
    next_slot  = idle_q;

    unique case (fsm_q)
      ttrrs_pkg::FsmIdle: begin
        if (start) begin
          valid_d    = 1'b1;
          status_d   = ttrrs_pkg::StatOk;
          switched_d = 1'b0;
          id_d       = ttrrs_pkg::IdW'(cur_q);
          case (kind_i)
            ttrrs_pkg::KindStart: begin
              if (free_found) begin
                state_d[free_slot] = ttrrs_pkg::SlotRunnable;
                join_d[free_slot]  = joinable_flag_i;
                id_d               = ttrrs_pkg::IdW'(free_slot);
              end else begin
                status_d = ttrrs_pkg::StatNoSlot;
                id_d     = '0;
              end
            end
            ttrrs_pkg::KindRun: begin
              if (!running_q) begin
                if (free_found) begin
                  state_d[free_slot] = ttrrs_pkg::SlotRunnable;
                  join_d[free_slot]  = 1'b0;
                  idle_d             = free_slot;
                  cur_d              = free_slot;
                  running_d          = 1'b1;
                  id_d               = ttrrs_pkg::IdW'(free_slot);
                  switched_d         = 1'b1;
                end else begin
                  status_d = ttrrs_pkg::StatNoSlot;
                  id_d     = '0;
                end
              end
            end
            default: begin
              if (!running_q) begin
                status_d = ttrrs_pkg::StatNotRunning;
                id_d     = '0;
              end else begin
                case (kind_i) inside
                  ttrrs_pkg::KindSchedule, ttrrs_pkg::KindExit, ttrrs_pkg::KindSuspend: begin
                    // Hold the result until the scan ends; consume pending events.
                    valid_d = 1'b0;
                    ev_d    = pend_q;
                    pend_d  = '0;
                    fsm_d   = ttrrs_pkg::FsmPrime;
                    if (kind_i == ttrrs_pkg::KindExit) begin
                      state_d[cur_q] = join_q[cur_q] ? ttrrs_pkg::SlotExited
                                                     : ttrrs_pkg::SlotUnused;
                    end else if (kind_i == ttrrs_pkg::KindSuspend) begin
                      state_d[cur_q] = ttrrs_pkg::SlotBlocked;
                      ram_we         = 1'b1;
                    end
                  end
                  ttrrs_pkg::KindResume: begin
                    pend_d = pend_q | channel_mask_i;
                  end
                  default: begin
                  end
                endcase
              end
            end
          endcase
        end
      end
      ttrrs_pkg::FsmPrime: begin
        look_d = rot_q;
        rot_d  = ttrrs_pkg::slot_inc(rot_q);
        cnt_d  = '0;
        fsm_d  = ttrrs_pkg::FsmScan;
      end
      ttrrs_pkg::FsmScan: begin
        // Examine look_q with its mask from the RAM; prefetch the next slot.
        look_d = rot_q;
        rot_d  = ttrrs_pkg::slot_inc(rot_q);
        cnt_d  = cnt_q + ttrrs_pkg::slot_t'(1);
        if (look_q != idle_q) begin
          if (state_q[look_q] == ttrrs_pkg::SlotBlocked && |(ram_rdata & ev_q)) begin
            state_d[look_q] = ttrrs_pkg::SlotRunnable;
            hit             = 1'b1;
          end
          if (state_q[look_q] == ttrrs_pkg::SlotRunnable) begin
            hit = 1'b1;
          end
        end
        next_slot = hit ? look_q : idle_q;
        if (hit || cnt_q == ttrrs_pkg::slot_t'(ttrrs_pkg::MaxThreads - 1)) begin
          // Drop the prefetch: pointer sits just past the last slot examined.
          rot_d      = ttrrs_pkg::slot_inc(look_q);
          cur_d      = next_slot;
          valid_d    = 1'b1;
          status_d   = ttrrs_pkg::StatOk;
          id_d       = ttrrs_pkg::IdW'(next_slot);
          switched_d = (next_slot != cur_q);
          fsm_d      = ttrrs_pkg::FsmIdle;
        end
      end
      default: begin
        fsm_d = ttrrs_pkg::FsmIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q     <= ttrrs_pkg::FsmIdle;
      cur_q     <= '0;
      idle_q    <= '0;
      rot_q     <= '0;
      running_q <= 1'b0;
      pend_q    <= '0;
      valid_q   <= 1'b0;
      for (int i = 0; i < ttrrs_pkg::MaxThreads; i++) begin
        state_q[i] <= ttrrs_pkg::SlotUnused;
        join_q[i]  <= 1'b0;
      end
    end else begin
      fsm_q     <= fsm_d;
      cur_q     <= cur_d;
      idle_q    <= idle_d;
      rot_q     <= rot_d;
      running_q <= running_d;
      pend_q    <= pend_d;
      valid_q   <= valid_d;
      state_q   <= state_d;
      join_q    <= join_d;
    end
  end

  always_ff @(posedge clk_i) begin
    look_q     <= look_d;
    cnt_q      <= cnt_d;
    ev_q       <= ev_d;
    status_q   <= status_d;
    id_q       <= id_d;
    switched_q <= switched_d;
  end

  assign busy        = (fsm_q != ttrrs_pkg::FsmIdle);
  assign valid_o     = valid_q;
  assign status_o    = status_q;
  assign thread_id_o = id_q;
  assign switched_o  = switched_q;

endmodule

FILE: rtl/core/ttrrs_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ttrrs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/ttrrs_checker.sv
// Port-level checker for the thread table round-robin scheduler, with its bind.
// Depends on ttrrs_pkg for the status codes.
module ttrrs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        valid_o,
  input logic [1:0]  status_o,
  input logic [3:0]  thread_id_o,
  input logic        switched_o
);

  // A refused request reports no thread and no switch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && (status_o == ttrrs_pkg::StatNotRunning || status_o == ttrrs_pkg::StatNoSlot)
      |-> (thread_id_o == '0) && !switched_o)
    else $error("refused request carries thread id or switch");

  // Busy only follows an accepted request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a request");

  // The end of a scan delivers its result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> valid_o)
    else $error("scan ended without a result");

  // A scan result never comes with the scheduler still busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !valid_o || $rose(busy))
    else $error("result strobe during a scan");

endmodule

bind thread_table_round_robin_scheduler ttrrs_checker u_ttrrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .valid_o     (valid_o),
  .status_o    (status_o),
  .thread_id_o (thread_id_o),
  .switched_o  (switched_o)
);
